/* rtl/bssc_pkg.sv */
// ----------------------------------------------------------------------------
// bssc_pkg
// Shared types and constants of the band-scan step controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bssc_pkg;

    localparam int FREQ_W = 16;
    localparam int CNT_W  = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic [FREQ_W-1:0] freq_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam cnt_t CNT_SAT = '1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAND_LOW       = 3'd0,
        CFG_BAND_HIGH      = 3'd1,
        CFG_STEP_SIZE      = 3'd2,
        CFG_POLL_PERIOD_MS = 3'd3,
        CFG_LONG_PRESS_MS  = 3'd4,
        CFG_CLICK_MS       = 3'd5
    } cfg_idx_t;

    localparam freq_t RST_BAND_LOW       = 16'd500;
    localparam freq_t RST_BAND_HIGH      = 16'd1710;
    localparam freq_t RST_STEP_SIZE      = 16'd10;
    localparam cnt_t  RST_POLL_PERIOD_MS = 16'd200;
    localparam cnt_t  RST_LONG_PRESS_MS  = 16'd375;
    localparam cnt_t  RST_CLICK_MS       = 16'd20;

    // Item commands
    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef struct packed {
        freq_t band_low;
        freq_t band_high;
        freq_t step_size;
        cnt_t  poll_period_ms;
        cnt_t  long_press_ms;
        cnt_t  click_ms;
    } cfg_t;

    typedef struct packed {
        logic  cmd;
        freq_t start_freq;
        logic  button_down;
        logic  tune_done;
        freq_t tuned_freq;
    } item_t;

    typedef struct packed {
        freq_t tune_freq;
        logic  finished;
    } result_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        cnt_t r;
        if (v == CNT_SAT)
        begin
            r = CNT_SAT;
        end
        else
        begin
            r = v + cnt_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/bssc_if.sv */
// ----------------------------------------------------------------------------
// bssc_if
// Channel interfaces: item input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bssc_item_if;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [15:0]           start_freq;
    logic                  button_down;
    logic                  tune_done;
    logic [15:0]           tuned_freq;

    modport source (output valid, cmd, start_freq, button_down, tune_done, tuned_freq,
                    input ready);
    modport sink   (input valid, cmd, start_freq, button_down, tune_done, tuned_freq,
                    output ready);
endinterface

interface bssc_result_if;
    logic                  valid;
    logic                  ready;
    logic [15:0]           tune_freq;
    logic                  finished;

    modport source (output valid, tune_freq, finished, input ready);
    modport sink   (input valid, tune_freq, finished, output ready);
endinterface

interface bssc_cfg_if;
    logic                  valid;
    logic                  ready;
    logic [2:0]            index;
    logic [15:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/band_scan_step_controller_core.sv */
// ----------------------------------------------------------------------------
// band_scan_step_controller_core
// Band-scan controller: times button presses, polls the tuner, steps the scan.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one request per millisecond tick (cmd tick) or a start request
//            (cmd start, with the home frequency in start_freq).
//   result : zero or one tune request per item; finished marks the final
//            request of a scan, which re-tunes to the home frequency.
//   cfg    : register writes (index 0..5), always ready; issue them only
//            while no request is in flight. Writes beyond index 5 are dropped.
//   Flow: an accepted request is held in the input register, then its
//   result is loaded into the output register, which drives the result port.
//   Throughput is one request per cycle while the result side is not stalled,
//   set by the single state update between the two registers.
//   A stalled result register holds its value; the input register still
//   takes a request when empty and then waits, so item.ready drops only when
//   both registers are full.
//   Reset clears the scan state and the valid flags of both registers and loads the default
//   band 500..1710, step 10, poll 200 ms, long press 375 ms, click 20 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module band_scan_step_controller_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bssc_item_if.sink        item,
    bssc_result_if.source    result,
    bssc_cfg_if.sink         cfg
);
    import bssc_pkg::*;

    cfg_t    cfg_q;
    item_t   in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    res_valid;
    result_t res;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    bssc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    bssc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .advance   (advance),
        .item      (in_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_reg.cmd         <= item.cmd;
            in_reg.start_freq  <= item.start_freq;
            in_reg.button_down <= item.button_down;
            in_reg.tune_done   <= item.tune_done;
            in_reg.tuned_freq  <= item.tuned_freq;
        end
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.tune_freq = out_reg.tune_freq;
    assign result.finished  = out_reg.finished;

endmodule

`default_nettype wire

/* rtl/bssc_cfg.sv */
// ----------------------------------------------------------------------------
// bssc_cfg
// Configuration register file, written through the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bssc_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [2:0]        wr_index,
    input  wire logic [15:0]       wr_data,
    output bssc_pkg::cfg_t         cfg
);
    import bssc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                CFG_BAND_LOW:       cfg_next.band_low       = wr_data;
                CFG_BAND_HIGH:      cfg_next.band_high      = wr_data;
                CFG_STEP_SIZE:      cfg_next.step_size      = wr_data;
                CFG_POLL_PERIOD_MS: cfg_next.poll_period_ms = wr_data;
                CFG_LONG_PRESS_MS:  cfg_next.long_press_ms  = wr_data;
                CFG_CLICK_MS:       cfg_next.click_ms       = wr_data;
                default:            cfg_next = cfg_reg; // drop writes beyond the map
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_low       <= RST_BAND_LOW;
            cfg_reg.band_high      <= RST_BAND_HIGH;
            cfg_reg.step_size      <= RST_STEP_SIZE;
            cfg_reg.poll_period_ms <= RST_POLL_PERIOD_MS;
            cfg_reg.long_press_ms  <= RST_LONG_PRESS_MS;
            cfg_reg.click_ms       <= RST_CLICK_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/bssc_core.sv */
// ----------------------------------------------------------------------------
// bssc_core
// Scan state and the per-item update: button timing, poll timer, target step.
// ----------------------------------------------------------------------------
`default_nettype none

module bssc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bssc_pkg::cfg_t    cfg,
    input  wire logic              advance,
    input  wire bssc_pkg::item_t   item,
    output logic                   res_valid,
    output bssc_pkg::result_t      res
);
    import bssc_pkg::*;

    logic  scanning_reg, scanning_next;
    logic  reverse_reg, reverse_next;
    logic  held_reg, held_next;
    cnt_t  press_reg, press_next;
    cnt_t  poll_reg, poll_next;
    freq_t target_reg, target_next;
    freq_t home_reg, home_next;

    cnt_t            dur;
    cnt_t            poll_inc;
    freq_t           step_val;
    logic [FREQ_W:0] up_sum;
    freq_t           dn_diff;

    // Next frequency of the scan, in the direction after this item's press
    always_comb
    begin
        up_sum  = {1'b0, target_reg} + {1'b0, cfg.step_size};
        dn_diff = target_reg - cfg.step_size;
        if (reverse_next)
        begin
            if ((cfg.step_size > target_reg) || (dn_diff < cfg.band_low))
            begin
                step_val = cfg.band_high;
            end
            else
            begin
                step_val = dn_diff;
            end
        end
        else
        begin
            if (up_sum > {1'b0, cfg.band_high})
            begin
                step_val = cfg.band_low;
            end
            else
            begin
                step_val = up_sum[FREQ_W-1:0];
            end
        end
    end

    always_comb
    begin
        scanning_next = scanning_reg;
        reverse_next  = reverse_reg;
        held_next     = held_reg;
        press_next    = press_reg;
        poll_next     = poll_reg;
        target_next   = target_reg;
        home_next     = home_reg;
        res_valid     = 1'b0;
        res.tune_freq = home_reg;
        res.finished  = 1'b0;
        dur           = sat_inc(press_reg);
        poll_inc      = sat_inc(poll_reg);

        if (cmd_t'(item.cmd) == CMD_START)
        begin
            home_next     = item.start_freq;
            target_next   = item.start_freq;
            scanning_next = 1'b1;
            held_next     = 1'b0;
            press_next    = '0;
            poll_next     = '0;
        end
        else if (scanning_reg)
        begin
            if (held_reg)
            begin
                if (!item.button_down)
                begin
                    // release: judge the press length
                    if (dur > cfg.long_press_ms)
                    begin
                        scanning_next = 1'b0;
                    end
                    else if (dur > cfg.click_ms)
                    begin
                        reverse_next = !reverse_reg;
                    end
                    held_next  = 1'b0;
                    press_next = '0;
                end
                else
                begin
                    press_next = dur;
                end
            end
            else if (item.button_down)
            begin
                held_next  = 1'b1;
                press_next = '0;
            end

            if (!scanning_next)
            begin
                // long press: re-tune home and finish
                poll_next     = '0;
                res_valid     = 1'b1;
                res.tune_freq = home_reg;
                res.finished  = 1'b1;
            end
            else if (poll_inc < cfg.poll_period_ms)
            begin
                poll_next = poll_inc;
            end
            else
            begin
                poll_next = '0;
                if (item.tune_done)
                begin
                    if (item.tuned_freq == target_reg)
                    begin
                        target_next = step_val;
                    end
                    res_valid     = 1'b1;
                    res.tune_freq = target_next;
                    res.finished  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg <= 1'b0;
            reverse_reg  <= 1'b0;
            held_reg     <= 1'b0;
            press_reg    <= '0;
            poll_reg     <= '0;
            target_reg   <= '0;
            home_reg     <= '0;
        end
        else if (advance)
        begin
            scanning_reg <= scanning_next;
            reverse_reg  <= reverse_next;
            held_reg     <= held_next;
            press_reg    <= press_next;
            poll_reg     <= poll_next;
            target_reg   <= target_next;
            home_reg     <= home_next;
        end
    end

endmodule

`default_nettype wire
